@@ rtl/core/combo_symbol_id_parser_assert.svh @@
// assertion macros used by the symbol id parser rtl
// expects clk and rst_n in the scope of each use
`ifndef COMBO_SYMBOL_ID_PARSER_ASSERT_SVH
`define COMBO_SYMBOL_ID_PARSER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CSIP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csip assertion failed");

// next-cycle implication, disabled during reset
`define CSIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csip assertion failed");

`endif

@@ rtl/core/csip_pkg.sv @@
// types and constants of the combo symbol id parser
// no dependencies
`default_nettype none

package csip_pkg;

  localparam int ID_BYTES  = 23;
  localparam int LEG_BYTES = 15;
  localparam int ID_MAX    = 23;
  localparam int SPLIT_LEN = 13;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef logic [ID_BYTES-1:0][7:0]  id_t;
  typedef logic [LEG_BYTES-1:0][7:0] leg_t;

  typedef enum logic [2:0] {
    KIND_SINGLE   = 3'd0,
    KIND_TIME     = 3'd1,
    KIND_PRICE    = 3'd2,
    KIND_STRADDLE = 3'd3,
    KIND_STRANGLE = 3'd4,
    KIND_CONV     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SIDE_NONE   = 2'd0,
    SIDE_SECOND = 2'd1,
    SIDE_SAME   = 2'd2
  } side_t;

  // slice layout picked by the decoder
  typedef enum logic [3:0] {
    LAY_REJECT = 4'd0,
    LAY_SHORT  = 4'd1,
    LAY_FUT8   = 4'd2,
    LAY_FUT11  = 4'd3,
    LAY_S13    = 4'd4,
    LAY_S16    = 4'd5,
    LAY_S18    = 4'd6,
    LAY_L15    = 4'd7,
    LAY_P16    = 4'd8,
    LAY_P21    = 4'd9,
    LAY_C23    = 4'd10,
    LAY_T18    = 4'd11
  } layout_t;

  typedef struct packed {
    layout_t    layout;
    logic [3:0] n1;
    logic [3:0] n2;
    kind_t      kind;
    side_t      side;
    logic       ok;
  } csip_dec_t;

  typedef struct packed {
    leg_t       first_leg;
    logic [3:0] first_len;
    leg_t       second_leg;
    logic [3:0] second_len;
    kind_t      kind;
    side_t      side;
    logic       accepted;
  } csip_res_t;

endpackage

`default_nettype wire

@@ rtl/core/csip_if.sv @@
// valid/ready channel interfaces for id input and parse result
// no dependencies
`default_nettype none

interface csip_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] id_bytes_low;
  logic [63:0] id_bytes_mid;
  logic [55:0] id_bytes_high;
  logic [5:0]  id_length;

  modport source (output valid, id_bytes_low, id_bytes_mid, id_bytes_high, id_length,
                  input ready);
  modport sink (input valid, id_bytes_low, id_bytes_mid, id_bytes_high, id_length,
                output ready);
endinterface

interface csip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] first_leg_low;
  logic [55:0] first_leg_high;
  logic [3:0]  first_leg_length;
  logic [63:0] second_leg_low;
  logic [55:0] second_leg_high;
  logic [3:0]  second_leg_length;
  logic [2:0]  combo_kind;
  logic [1:0]  side_rule;
  logic        accepted;

  modport source (output valid, first_leg_low, first_leg_high, first_leg_length,
                  second_leg_low, second_leg_high, second_leg_length, combo_kind,
                  side_rule, accepted, input ready);
  modport sink (input valid, first_leg_low, first_leg_high, first_leg_length,
                second_leg_low, second_leg_high, second_leg_length, combo_kind,
                side_rule, accepted, output ready);
endinterface

`default_nettype wire

@@ rtl/core/csip_decode.sv @@
// decode stage: length and separator checks pick the slice layout
// depends on csip_pkg
`default_nettype none

module csip_decode import csip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  id_t       up_id,
  input  logic [5:0] up_len,
  output logic      dn_valid,
  input  logic      dn_ready,
  output id_t       dn_id,
  output csip_dec_t dn_dec
);

  csip_dec_t dec_nxt;
  csip_dec_t dec_r;
  id_t       id_r;
  logic      v_r;
  logic      good;
  logic [7:0] sep;

  always_comb begin
    dec_nxt        = '0;
    dec_nxt.layout = LAY_REJECT;
    dec_nxt.kind   = KIND_SINGLE;
    dec_nxt.side   = SIDE_NONE;
    good           = 1'b1;
    sep            = up_id[10];
    if (up_len > 6'(ID_MAX)) begin
      dec_nxt.ok = 1'b0;
    end else if (up_len < 6'(SPLIT_LEN)) begin
      if ((up_len == 6'd8 || up_len == 6'd11) && up_id[5] == CH_SLASH) begin
        dec_nxt.layout = (up_len == 6'd11) ? LAY_FUT11 : LAY_FUT8;
        dec_nxt.n1     = 4'd5;
        dec_nxt.n2     = 4'd5;
        dec_nxt.kind   = KIND_TIME;
        dec_nxt.side   = SIDE_SECOND;
      end else begin
        dec_nxt.layout = LAY_SHORT;
        dec_nxt.n1     = up_len[3:0];
      end
      dec_nxt.ok = 1'b1;
    end else if (sep inside {CH_SLASH, CH_DASH, CH_COLON}) begin
      if (sep == CH_SLASH) begin
        dec_nxt.kind = KIND_TIME;
      end else if (sep == CH_DASH) begin
        dec_nxt.kind = KIND_CONV;
      end else if (up_len == 6'd13) begin
        dec_nxt.kind = KIND_STRADDLE;
      end else if (up_len == 6'd18) begin
        dec_nxt.kind = KIND_STRANGLE;
      end else begin
        good = 1'b0;
      end
      case (up_len)
        6'd13:   dec_nxt.layout = LAY_S13;
        6'd16:   dec_nxt.layout = LAY_S16;
        6'd18:   dec_nxt.layout = LAY_S18;
        default: good = 1'b0;
      endcase
      if (good) begin
        dec_nxt.n1   = 4'd10;
        dec_nxt.n2   = 4'd10;
        dec_nxt.side = (sep == CH_COLON) ? SIDE_SAME : SIDE_SECOND;
        dec_nxt.ok   = 1'b1;
      end else begin
        dec_nxt = '0;
      end
    end else begin
      case (up_len)
        6'd15: begin
          dec_nxt.layout = LAY_L15;
          dec_nxt.n1     = 4'd15;
        end
        6'd16: begin
          dec_nxt.layout = LAY_P16;
          dec_nxt.n1     = 4'd10;
          dec_nxt.n2     = 4'd10;
          dec_nxt.kind   = KIND_PRICE;
          dec_nxt.side   = SIDE_SECOND;
          good           = (up_id[8] == CH_SLASH);
        end
        6'd21: begin
          dec_nxt.layout = LAY_P21;
          dec_nxt.n1     = 4'd15;
          dec_nxt.n2     = 4'd15;
          dec_nxt.kind   = KIND_PRICE;
          dec_nxt.side   = SIDE_SECOND;
          good           = (up_id[13] == CH_SLASH);
        end
        6'd23: begin
          dec_nxt.layout = LAY_C23;
          dec_nxt.n1     = 4'd15;
          dec_nxt.n2     = 4'd15;
          dec_nxt.kind   = KIND_STRANGLE;
          dec_nxt.side   = SIDE_SAME;
          good           = (up_id[15] == CH_COLON);
        end
        6'd18: begin
          dec_nxt.layout = LAY_T18;
          dec_nxt.n1     = 4'd15;
          dec_nxt.n2     = 4'd15;
          dec_nxt.side   = (up_id[15] == CH_COLON) ? SIDE_SAME : SIDE_SECOND;
          if (up_id[15] == CH_SLASH) begin
            dec_nxt.kind = KIND_TIME;
          end else if (up_id[15] == CH_COLON) begin
            dec_nxt.kind = KIND_STRADDLE;
          end else if (up_id[15] == CH_DASH) begin
            dec_nxt.kind = KIND_CONV;
          end else begin
            good = 1'b0;
          end
        end
        default: good = 1'b0;
      endcase
      if (good) begin
        dec_nxt.ok = 1'b1;
      end else begin
        dec_nxt = '0;
      end
    end
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_id    = id_r;
  assign dn_dec   = dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      id_r  <= up_id;
      dec_r <= dec_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/csip_assemble.sv @@
// assemble stage: slice copies build the two legs, output register
// depends on csip_pkg and combo_symbol_id_parser_assert.svh
`default_nettype none
`include "combo_symbol_id_parser_assert.svh"

module csip_assemble import csip_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  id_t       up_id,
  input  csip_dec_t up_dec,
  output logic      dn_valid,
  input  logic      dn_ready,
  output csip_res_t dn_res
);

  leg_t      l1_nxt;
  leg_t      l2_nxt;
  csip_res_t res_nxt;
  csip_res_t res_r;
  logic      v_r;

  always_comb begin
    l1_nxt = '0;
    l2_nxt = '0;
    case (up_dec.layout)
      LAY_SHORT: begin
        for (int i = 0; i < LEG_BYTES; i++) begin
          if (4'(i) < up_dec.n1) l1_nxt[i] = up_id[i];
        end
      end
      LAY_FUT8: begin
        l1_nxt[4:0] = up_id[4:0];
        l2_nxt[2:0] = up_id[2:0];
        l2_nxt[4:3] = up_id[7:6];
      end
      LAY_FUT11: begin
        l1_nxt[4:0] = up_id[4:0];
        l2_nxt[4:0] = up_id[10:6];
      end
      LAY_S13: begin
        l1_nxt[9:0] = up_id[9:0];
        l2_nxt[7:0] = up_id[7:0];
        l2_nxt[9:8] = up_id[12:11];
      end
      LAY_S16: begin
        l1_nxt[9:0] = up_id[9:0];
        l2_nxt[2:0] = up_id[13:11];
        l2_nxt[7:3] = up_id[7:3];
        l2_nxt[9:8] = up_id[15:14];
      end
      LAY_S18: begin
        l1_nxt[9:0] = up_id[9:0];
        l2_nxt[2:0] = up_id[2:0];
        l2_nxt[9:3] = up_id[17:11];
      end
      LAY_L15: begin
        l1_nxt = up_id[14:0];
      end
      LAY_P16: begin
        l1_nxt[7:0] = up_id[7:0];
        l1_nxt[9:8] = up_id[15:14];
        l2_nxt[2:0] = up_id[2:0];
        l2_nxt[9:3] = up_id[15:9];
      end
      LAY_P21: begin
        l1_nxt[12:0]  = up_id[12:0];
        l1_nxt[14:13] = up_id[20:19];
        l2_nxt[7:0]   = up_id[7:0];
        l2_nxt[14:8]  = up_id[20:14];
      end
      LAY_C23: begin
        l1_nxt       = up_id[14:0];
        l2_nxt[7:0]  = up_id[7:0];
        l2_nxt[14:8] = up_id[22:16];
      end
      LAY_T18: begin
        l1_nxt        = up_id[14:0];
        l2_nxt[12:0]  = up_id[12:0];
        l2_nxt[14:13] = up_id[17:16];
      end
      default: begin
        l1_nxt = '0;
        l2_nxt = '0;
      end
    endcase
    res_nxt.first_leg  = l1_nxt;
    res_nxt.first_len  = up_dec.n1;
    res_nxt.second_leg = l2_nxt;
    res_nxt.second_len = up_dec.n2;
    res_nxt.kind       = up_dec.kind;
    res_nxt.side       = up_dec.side;
    res_nxt.accepted   = up_dec.ok;
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= res_nxt;
    end
  end

  // a rejected id leaves every field zero
  `CSIP_ASSERT_IMPL(a_reject_zero, v_r && !res_r.accepted,
    res_r.first_len == 4'd0 && res_r.second_len == 4'd0 && res_r.kind == KIND_SINGLE &&
    res_r.side == SIDE_NONE && res_r.first_leg == '0 && res_r.second_leg == '0)
  // single legs carry no second leg and no side rule
  `CSIP_ASSERT_IMPL(a_single_leg, v_r && res_r.accepted && res_r.kind == KIND_SINGLE,
    res_r.second_len == 4'd0 && res_r.side == SIDE_NONE)
  // both legs of a combination share one length
  `CSIP_ASSERT_IMPL(a_leg_lengths, v_r && res_r.second_len != 4'd0,
    res_r.first_len == res_r.second_len && res_r.side != SIDE_NONE)

endmodule

`default_nettype wire

@@ rtl/core/combo_symbol_id_parser.sv @@
// top level of the combo symbol id parser: input register, decode, assemble
// depends on csip_pkg, csip_if, csip_decode and csip_assemble
`default_nettype none

// Splits a derivative symbol id of up to 23 bytes into two leg ids, a
// combination kind and a side rule. One id per clock is taken on in_ch
// while in_ch ready is high, and one result per id leaves on out_ch, in
// order. The path is three register stages deep (input register, layout
// decode, leg assembly into the output register), each registering the id
// in turn before out_ch valid rises. There is no loop or shared unit: each
// stage holds one id and moves on whenever the stage after it is empty or
// moving, so the sustained rate is one id per cycle while out_ch is ready,
// and a stalled output only stops ids once the three stages are full.
// Ready on in_ch is combinational from out_ch ready through the three stage
// valid bits. No configuration, no state kept between ids; a rejected id
// gives a result with every field zero.
module combo_symbol_id_parser import csip_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  csip_in_if.sink  in_ch,
  csip_out_if.source out_ch
);

  // input register stage
  logic       s1_v_r;
  id_t        s1_id_r;
  logic [5:0] s1_len_r;
  logic       s1_ready;

  // decode stage to assemble stage
  logic       s2_valid;
  logic       s2_ready;
  id_t        s2_id;
  csip_dec_t  s2_dec;

  csip_res_t  res;

  // stage moves when it is empty or the decode stage takes its id
  assign in_ch.ready = !s1_v_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_id_r  <= {in_ch.id_bytes_high, in_ch.id_bytes_mid, in_ch.id_bytes_low};
      s1_len_r <= in_ch.id_length;
    end
  end

  // length and separator checks
  csip_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_v_r),
    .up_ready (s1_ready),
    .up_id    (s1_id_r),
    .up_len   (s1_len_r),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_id    (s2_id),
    .dn_dec   (s2_dec)
  );

  // slice copies into the legs, holds the output transaction
  csip_assemble u_assemble (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_id    (s2_id),
    .up_dec   (s2_dec),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_res   (res)
  );

  // leg bytes 0..7 low word, 8..14 high word
  assign out_ch.first_leg_low     = res.first_leg[7:0];
  assign out_ch.first_leg_high    = res.first_leg[14:8];
  assign out_ch.first_leg_length  = res.first_len;
  assign out_ch.second_leg_low    = res.second_leg[7:0];
  assign out_ch.second_leg_high   = res.second_leg[14:8];
  assign out_ch.second_leg_length = res.second_len;
  assign out_ch.combo_kind        = res.kind;
  assign out_ch.side_rule         = res.side;
  assign out_ch.accepted          = res.accepted;

endmodule

`default_nettype wire
